// ===== hdl/sphaser_pkg.sv =====
`default_nettype none
package sphaser_pkg;

    localparam int STATE_W = 24;
    localparam int FRAC_BITS = STATE_W - 4;
    localparam int IN_SHIFT = FRAC_BITS - 15;
    localparam int PROD_W = STATE_W + 18;
    localparam int LFO_TABLE_DEPTH = 1024;
    localparam int LFO_IDX_W = 10;
    localparam int GAIN_W = 17;
    localparam logic [16:0] UNITY_Q16 = 17'd65536;

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] ONE_Q24 = 64'd1 << 24;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [2:0] CFG_LFO_STEP = 3'd0;
    localparam logic [2:0] CFG_START_PHASE = 3'd1;
    localparam logic [2:0] CFG_FEEDBACK = 3'd2;
    localparam logic [2:0] CFG_DEPTH = 3'd3;
    localparam logic [2:0] CFG_DRY_WET = 3'd4;
    localparam logic [2:0] CFG_STAGES = 3'd5;

    typedef enum logic [2:0] {
        TOP_IDLE,
        TOP_LFO,
        TOP_START,
        TOP_RUN,
        TOP_MIX
    } top_state_t;

    typedef enum logic [1:0] {
        LN_IDLE,
        LN_MUL1,
        LN_MUL2,
        LN_UPD
    } lane_state_t;

    typedef logic [16:0] rom_t [LFO_TABLE_DEPTH];

    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [47:0] v);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        hi = (48'sd1 <<< (STATE_W - 1)) - 48'sd1;
        lo = -hi - 48'sd1;
        if (v > hi) begin
            sat_state = hi[STATE_W-1:0];
        end else if (v < lo) begin
            sat_state = lo[STATE_W-1:0];
        end else begin
            sat_state = v[STATE_W-1:0];
        end
    endfunction

    // Taylor cosine, Q30
    function automatic logic [63:0] cos_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        longint sum;
        x2 = (x * x) >> 30;
        term = ONE_Q30;
        sum = longint'(ONE_Q30);
        for (int n = 1; n <= 9; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) sum = 0;
        if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
        cos_q30 = 64'(sum);
    endfunction

    // exp of a Q30 argument as exp(x/8)^8, Q24 result
    function automatic logic [63:0] exp_q24(input logic [63:0] e);
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] v;
        z = e >> 3;
        term = ONE_Q30;
        v = ONE_Q30;
        for (int n = 1; n <= 14; n++) begin
            term = ((term * z) >> 30) / 64'(n);
            v = v + term;
        end
        v = (v * v) >> 30;
        v = (v * v) >> 30;
        v = v >> 6;
        exp_q24 = (v * v) >> 24;
    endfunction

    localparam logic [63:0] ROM_DEN = exp_q24(64'd4 << 30) - ONE_Q24;

    function automatic rom_t build_rom();
        rom_t r;
        logic [63:0] y;
        logic [63:0] c;
        logic [63:0] u;
        logic [63:0] ex;
        logic [63:0] q;
        for (int k = 0; k < LFO_TABLE_DEPTH; k++) begin
            y = (PI_Q30 * 64'(k)) / LFO_TABLE_DEPTH;
            if (y > HALF_PI_Q30) y = PI_Q30 - y;
            c = cos_q30(y);
            u = (c * c) >> 30;
            ex = exp_q24(u << 2);
            ex = (ex > ONE_Q24) ? ex - ONE_Q24 : 64'd0;
            q = (ex * 64'd65536 + ROM_DEN / 2) / ROM_DEN;
            r[k] = (q > 64'd65536) ? UNITY_Q16 : q[16:0];
        end
        build_rom = r;
    endfunction

    localparam rom_t LFO_ROM = build_rom();

endpackage
`default_nettype wire

// ===== hdl/sphaser_ram.sv =====
`default_nettype none
module sphaser_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 24,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== hdl/sphaser_lfo.sv =====
`default_nettype none
module sphaser_lfo #(
    parameter int LFO_UPDATE_INTERVAL = 20,
    localparam int TW = (LFO_UPDATE_INTERVAL > 1) ? $clog2(LFO_UPDATE_INTERVAL) : 1
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        tick,
    input  wire logic [31:0] lfo_step,
    input  wire logic [31:0] phase_offset,
    input  wire logic [16:0] depth,
    output logic      [16:0] gain
);
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [31:0] phase;
    logic [TW-1:0] cnt_reg;
    logic [TW:0] cnt_inc;
    logic upd_reg;
    logic [16:0] rom_q_reg;
    logic [16:0] gain_reg;
    logic [16:0] dep;
    logic [33:0] prod;
    logic [17:0] scaled;

    assign acc_next = acc_reg + lfo_step;
    assign phase = acc_next + phase_offset;
    assign cnt_inc = {1'b0, cnt_reg} + {{TW{1'b0}}, 1'b1};
    assign dep = (depth > sphaser_pkg::UNITY_Q16) ? sphaser_pkg::UNITY_Q16 : depth;
    assign prod = 34'(rom_q_reg) * 34'(dep) + 34'd32768;
    assign scaled = prod[33:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            cnt_reg <= '0;
            upd_reg <= 1'b0;
            gain_reg <= '0;
        end else begin
            if (tick) begin
                acc_reg <= acc_next;
                upd_reg <= (cnt_reg == '0);
                if (32'(cnt_inc) >= LFO_UPDATE_INTERVAL) begin
                    cnt_reg <= '0;
                end else begin
                    cnt_reg <= cnt_inc[TW-1:0];
                end
            end else begin
                upd_reg <= 1'b0;
            end
            if (upd_reg) begin
                gain_reg <= (scaled > 18'(sphaser_pkg::UNITY_Q16)) ? 17'd0
                          : 17'(18'(sphaser_pkg::UNITY_Q16) - scaled);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tick) begin
            rom_q_reg <= sphaser_pkg::LFO_ROM[phase[31 -: sphaser_pkg::LFO_IDX_W]];
        end
    end

    assign gain = gain_reg;
endmodule
`default_nettype wire

// ===== hdl/sphaser_lane.sv =====
`default_nettype none
module sphaser_lane #(
    parameter int MAX_STAGES = 24,
    localparam int IDX_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1,
    localparam int CNT_W = $clog2(MAX_STAGES + 1),
    localparam int SW = sphaser_pkg::STATE_W
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic signed [15:0]   sample,
    input  wire logic signed [15:0]   coef,
    input  wire logic        [16:0]   gain,
    input  wire logic [CNT_W-1:0]     stage_num,
    output logic                      done,
    output logic signed [SW-1:0]      m_out,
    output logic signed [SW-1:0]      x_out
);
    localparam int PW = sphaser_pkg::PROD_W;
    localparam int XS = sphaser_pkg::IN_SHIFT;

    sphaser_pkg::lane_state_t state_reg, state_next;
    logic signed [SW-1:0] m_reg, m_next;
    logic signed [SW-1:0] x_reg, x_next;
    logic signed [SW-1:0] old_reg, old_next;
    logic signed [PW-1:0] p_reg, p_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MAX_STAGES-1:0] valid_reg, valid_next;

    logic signed [SW-1:0] x_in;
    logic signed [39:0] fb_prod;
    logic signed [24:0] fb_rnd;
    logic signed [SW-1:0] m_start;
    logic signed [SW-1:0] old_val;
    logic signed [PW-1:0] p_sum;
    logic signed [PW-17:0] p_rnd;
    logic signed [SW-1:0] nw;
    logic signed [17:0] g_s;
    logic [CNT_W-1:0] cnt_inc;

    logic ram_we, ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [SW-1:0] ram_rdata;

    assign x_in = $signed({{(SW - 16 - XS){sample[15]}}, sample, {XS{1'b0}}});
    assign fb_prod = m_reg * coef + 40'sd16384;
    assign fb_rnd = fb_prod[39:15];
    assign m_start = sphaser_pkg::sat_state(48'(x_in) + 48'(fb_rnd));
    assign g_s = $signed({1'b0, gain});
    assign old_val = valid_reg[cnt_reg[IDX_W-1:0]] ? $signed(ram_rdata) : '0;
    assign p_sum = p_reg + PW'(32768);
    assign p_rnd = p_sum[PW-1:16];
    assign nw = sphaser_pkg::sat_state(48'(p_rnd) + 48'(m_reg));
    assign cnt_inc = cnt_reg + CNT_W'(1);

    always_comb begin
        state_next = state_reg;
        m_next = m_reg;
        x_next = x_reg;
        old_next = old_reg;
        p_next = p_reg;
        cnt_next = cnt_reg;
        valid_next = valid_reg;
        ram_we = 1'b0;
        ram_re = 1'b0;
        ram_raddr = cnt_reg[IDX_W-1:0];
        done = 1'b0;
        unique case (state_reg)
            sphaser_pkg::LN_IDLE: begin
                if (start) begin
                    x_next = x_in;
                    m_next = m_start;
                    cnt_next = '0;
                    ram_re = 1'b1;
                    ram_raddr = '0;
                    state_next = sphaser_pkg::LN_MUL1;
                end
            end
            sphaser_pkg::LN_MUL1: begin
                old_next = old_val;
                p_next = g_s * old_val;
                state_next = sphaser_pkg::LN_MUL2;
            end
            sphaser_pkg::LN_MUL2: begin
                ram_we = 1'b1;
                valid_next[cnt_reg[IDX_W-1:0]] = 1'b1;
                p_next = g_s * nw;
                state_next = sphaser_pkg::LN_UPD;
            end
            sphaser_pkg::LN_UPD: begin
                m_next = sphaser_pkg::sat_state(48'(old_reg) - 48'(p_rnd));
                cnt_next = cnt_inc;
                if (cnt_inc >= stage_num) begin
                    done = 1'b1;
                    state_next = sphaser_pkg::LN_IDLE;
                end else begin
                    ram_re = 1'b1;
                    ram_raddr = cnt_inc[IDX_W-1:0];
                    state_next = sphaser_pkg::LN_MUL1;
                end
            end
            default: state_next = sphaser_pkg::LN_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sphaser_pkg::LN_IDLE;
            m_reg <= '0;
            cnt_reg <= '0;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            m_reg <= m_next;
            cnt_reg <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        old_reg <= old_next;
        p_reg <= p_next;
    end

    sphaser_ram #(
        .WIDTH(SW),
        .DEPTH(MAX_STAGES)
    ) u_mem (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (nw),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_out = m_reg;
    assign x_out = x_reg;
endmodule
`default_nettype wire

// ===== hdl/sphaser_mix.sv =====
`default_nettype none
module sphaser_mix #(
    localparam int SW = sphaser_pkg::STATE_W
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    output logic                    ready,
    input  wire logic signed [SW-1:0] m_l,
    input  wire logic signed [SW-1:0] m_r,
    input  wire logic signed [SW-1:0] x_l,
    input  wire logic signed [SW-1:0] x_r,
    input  wire logic        [16:0] dry_wet,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic             [31:0] m_tdata    // left_out, right_out
);
    localparam int PW = sphaser_pkg::PROD_W;
    localparam int RS = sphaser_pkg::FRAC_BITS + 1;

    logic busy_reg;
    logic valid_reg;
    logic signed [PW-1:0] pa_l_reg, pa_r_reg;
    logic signed [SW-1:0] xl_reg, xr_reg;
    logic [15:0] out_l_reg, out_r_reg;

    logic [16:0] dw;
    logic signed [17:0] wet_s, dry_s;
    logic signed [PW:0] sum_l, sum_r;
    logic signed [PW-RS:0] rnd_l, rnd_r;

    function automatic logic [15:0] sat16(input logic signed [PW-RS:0] v);
        if (v > (PW-RS+1)'(32767)) begin
            sat16 = 16'h7FFF;
        end else if (v < -(PW-RS+1)'(32768)) begin
            sat16 = 16'h8000;
        end else begin
            sat16 = v[15:0];
        end
    endfunction

    assign dw = (dry_wet > sphaser_pkg::UNITY_Q16) ? sphaser_pkg::UNITY_Q16 : dry_wet;
    assign wet_s = $signed({1'b0, dw});
    assign dry_s = $signed({1'b0, 17'(sphaser_pkg::UNITY_Q16 - dw)});
    assign sum_l = (PW+1)'(pa_l_reg) + (PW+1)'(xl_reg * dry_s) + (PW+1)'(1 <<< (RS - 1));
    assign sum_r = (PW+1)'(pa_r_reg) + (PW+1)'(xr_reg * dry_s) + (PW+1)'(1 <<< (RS - 1));
    assign rnd_l = sum_l[PW:RS];
    assign rnd_r = sum_r[PW:RS];
    assign ready = !busy_reg && !valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (start && ready) begin
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                busy_reg <= 1'b0;
                valid_reg <= 1'b1;
            end else if (valid_reg && m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && ready) begin
            pa_l_reg <= m_l * wet_s;
            pa_r_reg <= m_r * wet_s;
            xl_reg <= x_l;
            xr_reg <= x_r;
        end
        if (busy_reg) begin
            out_l_reg <= sat16(rnd_l);
            out_r_reg <= sat16(rnd_r);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata = {out_r_reg, out_l_reg};
endmodule
`default_nettype wire

// ===== hdl/stereo_phaser_allpass_lfo.sv =====
`default_nettype none
// Stereo phaser. One frame in (s_tdata), one frame out (m_tdata). Left and right each
// run in their own lane through stage_count first-order allpass stages, walked serially
// one stage at a time through the lane states MUL1, MUL2 and UPD, with per-stage state
// held in a read-write RAM. A new frame is taken once the previous one has gone to the
// output register, which holds the result until m_tready. Configuration writes take
// effect at once; write them only while no frame is in flight.
module stereo_phaser_allpass_lfo #(
    parameter int MAX_STAGES = 24,
    parameter int LFO_UPDATE_INTERVAL = 20
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,     // left_in, right_in
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,     // left_out, right_out
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int CNT_W = $clog2(MAX_STAGES + 1);
    localparam int SW = sphaser_pkg::STATE_W;

    logic [31:0] lfo_step_reg;
    logic [31:0] start_phase_reg;
    logic [15:0] coef_reg;
    logic [16:0] depth_reg;
    logic [16:0] dry_wet_reg;
    logic [4:0] stages_reg;

    sphaser_pkg::top_state_t state_reg, state_next;
    logic [15:0] left_reg, right_reg;

    logic accept;
    logic lane_start, mix_start, mix_ready;
    logic done_l, done_r;
    logic [16:0] gain;
    logic [CNT_W-1:0] stage_num;
    logic signed [SW-1:0] m_l, m_r, x_l, x_r;

    assign cfg_ready = 1'b1;
    assign accept = s_tvalid && s_tready;

    always_comb begin
        if (stages_reg == 5'd0) begin
            stage_num = CNT_W'(1);
        end else if (32'(stages_reg) > MAX_STAGES) begin
            stage_num = CNT_W'(MAX_STAGES);
        end else begin
            stage_num = CNT_W'(stages_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfo_step_reg <= 32'd35791;
            start_phase_reg <= 32'd0;
            coef_reg <= 16'd0;
            depth_reg <= 17'd26214;
            dry_wet_reg <= 17'd32768;
            stages_reg <= 5'd2;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                sphaser_pkg::CFG_LFO_STEP:    lfo_step_reg <= cfg_data;
                sphaser_pkg::CFG_START_PHASE: start_phase_reg <= cfg_data;
                sphaser_pkg::CFG_FEEDBACK:    coef_reg <= cfg_data[15:0];
                sphaser_pkg::CFG_DEPTH:       depth_reg <= cfg_data[16:0];
                sphaser_pkg::CFG_DRY_WET:     dry_wet_reg <= cfg_data[16:0];
                sphaser_pkg::CFG_STAGES:      stages_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready = 1'b0;
        lane_start = 1'b0;
        mix_start = 1'b0;
        unique case (state_reg)
            sphaser_pkg::TOP_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) state_next = sphaser_pkg::TOP_LFO;
            end
            // gain settles during this cycle
            sphaser_pkg::TOP_LFO: state_next = sphaser_pkg::TOP_START;
            sphaser_pkg::TOP_START: begin
                lane_start = 1'b1;
                state_next = sphaser_pkg::TOP_RUN;
            end
            sphaser_pkg::TOP_RUN: begin
                if (done_l && done_r) state_next = sphaser_pkg::TOP_MIX;
            end
            sphaser_pkg::TOP_MIX: begin
                if (mix_ready) begin
                    mix_start = 1'b1;
                    state_next = sphaser_pkg::TOP_IDLE;
                end
            end
            default: state_next = sphaser_pkg::TOP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sphaser_pkg::TOP_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            left_reg <= s_tdata[15:0];
            right_reg <= s_tdata[31:16];
        end
    end

    sphaser_lfo #(
        .LFO_UPDATE_INTERVAL(LFO_UPDATE_INTERVAL)
    ) u_lfo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick         (accept),
        .lfo_step     (lfo_step_reg),
        .phase_offset (start_phase_reg),
        .depth        (depth_reg),
        .gain         (gain)
    );

    sphaser_lane #(.MAX_STAGES(MAX_STAGES)) u_lane_l (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (lane_start),
        .sample    ($signed(left_reg)),
        .coef      ($signed(coef_reg)),
        .gain      (gain),
        .stage_num (stage_num),
        .done      (done_l),
        .m_out     (m_l),
        .x_out     (x_l)
    );

    sphaser_lane #(.MAX_STAGES(MAX_STAGES)) u_lane_r (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (lane_start),
        .sample    ($signed(right_reg)),
        .coef      ($signed(coef_reg)),
        .gain      (gain),
        .stage_num (stage_num),
        .done      (done_r),
        .m_out     (m_r),
        .x_out     (x_r)
    );

    sphaser_mix u_mix (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mix_start),
        .ready    (mix_ready),
        .m_l      (m_l),
        .m_r      (m_r),
        .x_l      (x_l),
        .x_r      (x_r),
        .dry_wet  (dry_wet_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );
endmodule
`default_nettype wire

// ===== sim/stereo_phaser_allpass_lfo_tb.sv =====
`default_nettype none
module stereo_phaser_allpass_lfo_tb;

    localparam int N_STAGES = 24;
    localparam int LFO_INTERVAL = 20;
    localparam int N_RANDOM = 2000;

    typedef struct packed {
        logic signed [15:0] right;
        logic signed [15:0] left;
    } frame_t;

    typedef struct {
        frame_t frm;
        logic   has_exp;
        frame_t exp_frm;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = sphaser_pkg::CFG_LFO_STEP;
    logic [31:0] cfg_data = '0;

    always #1 aclk = ~aclk;

    stereo_phaser_allpass_lfo uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state and registers
    logic [31:0]        p_step, p_start;
    logic signed [15:0] p_fb;
    logic [16:0]        p_depth, p_wet;
    logic [4:0]         p_stages;
    longint             ap_mem [2][N_STAGES];
    longint             fb_mem [2];
    longint             gain;
    int                 tick;
    logic [31:0]        phase_acc;

    frame_t expected_frames [$];
    int     n_errors = 0;
    int     n_out = 0;
    int     n_sent = 0;
    logic   hold_off = 1'b0;

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rshr(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint sat(longint v, int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    task automatic phaser_reset_state();
        for (int c = 0; c < 2; c++) begin
            for (int s = 0; s < N_STAGES; s++) ap_mem[c][s] = 0;
            fb_mem[c] = 0;
        end
        gain = 0;
        tick = 0;
        phase_acc = '0;
        p_step = 32'd35791;
        p_start = '0;
        p_fb = '0;
        p_depth = 17'd26214;
        p_wet = 17'd32768;
        p_stages = 5'd2;
    endtask

    task automatic phaser_write_reg(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            sphaser_pkg::CFG_LFO_STEP:    p_step = val;
            sphaser_pkg::CFG_START_PHASE: p_start = val;
            sphaser_pkg::CFG_FEEDBACK:    p_fb = val[15:0];
            sphaser_pkg::CFG_DEPTH:       p_depth = val[16:0];
            sphaser_pkg::CFG_DRY_WET:     p_wet = val[16:0];
            sphaser_pkg::CFG_STAGES:      p_stages = val[4:0];
            default: ;
        endcase
    endtask

    function automatic frame_t phaser_predict(frame_t f);
        longint x [2];
        longint m [2];
        longint dep, dw, old, nw, mix, sh, scaled;
        int n;
        logic [31:0] ph;
        logic [63:0] idx;
        frame_t r;
        dep = p_depth > 65536 ? 65536 : p_depth;
        dw = p_wet > 65536 ? 65536 : p_wet;
        n = p_stages < 1 ? 1 : (p_stages > N_STAGES ? N_STAGES : p_stages);
        x[0] = longint'(f.left) <<< sphaser_pkg::IN_SHIFT;
        x[1] = longint'(f.right) <<< sphaser_pkg::IN_SHIFT;
        for (int c = 0; c < 2; c++)
            m[c] = sat(x[c] + rshr(fb_mem[c] * longint'(p_fb), 15), sphaser_pkg::STATE_W);
        phase_acc = phase_acc + p_step;
        if (tick == 0) begin
            ph = phase_acc + p_start;
            idx = (64'(ph) * sphaser_pkg::LFO_TABLE_DEPTH) >> 32;
            sh = sphaser_pkg::LFO_ROM[idx[9:0]];
            scaled = (sh * dep + 32768) >>> 16;
            gain = 65536 - (scaled > 65536 ? 65536 : scaled);
        end
        tick++;
        if (tick >= LFO_INTERVAL) tick = 0;
        for (int s = 0; s < n; s++) begin
            for (int c = 0; c < 2; c++) begin
                old = ap_mem[c][s];
                nw = sat(rshr(gain * old, 16) + m[c], sphaser_pkg::STATE_W);
                ap_mem[c][s] = nw;
                m[c] = sat(old - rshr(gain * nw, 16), sphaser_pkg::STATE_W);
            end
        end
        for (int c = 0; c < 2; c++) begin
            fb_mem[c] = m[c];
            mix = m[c] * dw + x[c] * (65536 - dw);
            mix = sat(rshr(mix, sphaser_pkg::FRAC_BITS + 1), 16);
            if (c == 0) r.left = mix[15:0];
            else r.right = mix[15:0];
        end
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // one frame request; predictor runs at acceptance
    task automatic send_frame(input frame_t f, input logic has_exp, input frame_t exp_f);
        frame_t p;
        int g;
        s_tvalid <= 1'b1;
        s_tdata <= f;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p = phaser_predict(f);
        n_sent++;
        if (has_exp && p !== exp_f) begin
            n_errors++;
            if (n_errors <= 10)
                $display("directed row mismatch: table %h predictor %h", exp_f, p);
        end
        expected_frames.push_back(p);
        g = gap_len();
        if (g != 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        phaser_write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic frame_t rand_frame();
        frame_t f;
        int k;
        k = $urandom_range(0, 9);
        f = $urandom;
        if (k == 0) f.left = 16'sh7fff;
        if (k == 1) f.right = 16'sh8000;
        if (k == 2) f = '0;
        return f;
    endfunction

    // result side: random stall plus checking
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_frames.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                frame_t e;
                e = expected_frames.pop_front();
                n_out++;
                if (m_tdata[15:0] !== e.left || m_tdata[31:16] !== e.right) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("result %0d: expected L %0d R %0d, got L %0d R %0d",
                                 n_out, e.left, e.right,
                                 $signed(m_tdata[15:0]), $signed(m_tdata[31:16]));
                end
            end
        end
    end

    initial begin
        int g;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
            end else begin
                g = gap_len();
                if (g == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    repeat (g - 1) @(posedge aclk);
                end
            end
        end
    end

    stim_row_t directed [$];

    initial begin
        stim_row_t row;
        frame_t f;
        logic [31:0] vals [6];
        phaser_reset_state();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: first row after reset has zero state, gain from rom[0]
        row.frm = '0; row.has_exp = 1'b1; row.exp_frm = '0; directed.push_back(row);
        row.has_exp = 1'b0;
        row.frm = {16'sh7fff, 16'sh7fff}; directed.push_back(row);
        row.frm = {16'sh8000, 16'sh8000}; directed.push_back(row);
        row.frm = {16'sh8000, 16'sh7fff}; directed.push_back(row);
        row.frm = {16'sh0001, 16'shffff}; directed.push_back(row);
        for (int i = 0; i < 5; i++) begin
            row.frm = {16'sh5555, 16'shaaaa}; directed.push_back(row);
        end
        foreach (directed[i]) send_frame(directed[i].frm, directed[i].has_exp,
                                         directed[i].exp_frm);
        drain();

        // extreme settings: full wet, full depth, max feedback, max stages
        write_reg(sphaser_pkg::CFG_DRY_WET, 32'd65536);
        write_reg(sphaser_pkg::CFG_DEPTH, 32'd65536);
        write_reg(sphaser_pkg::CFG_FEEDBACK, 32'h0000_7fff);
        write_reg(sphaser_pkg::CFG_STAGES, 32'd24);
        write_reg(sphaser_pkg::CFG_LFO_STEP, 32'hffff_ffff);
        write_reg(sphaser_pkg::CFG_START_PHASE, 32'h8000_0000);
        for (int i = 0; i < 6; i++) send_frame({16'sh7fff, 16'sh8000}, 1'b0, '0);
        drain();
        // fully dry passes input unchanged
        write_reg(sphaser_pkg::CFG_DRY_WET, 32'd0);
        write_reg(sphaser_pkg::CFG_FEEDBACK, 32'h0000_8000);
        write_reg(sphaser_pkg::CFG_STAGES, 32'd0);
        f = {16'sh1234, 16'sh8000};
        send_frame(f, 1'b1, f);
        send_frame({16'sh7fff, 16'sh0000}, 1'b1, {16'sh7fff, 16'sh0000});
        drain();
        // out-of-range register codes
        write_reg(sphaser_pkg::CFG_STAGES, 32'd31);
        write_reg(sphaser_pkg::CFG_DEPTH, 32'h1ffff);
        write_reg(sphaser_pkg::CFG_DRY_WET, 32'h1ffff);
        send_frame({16'sh4000, 16'shc000}, 1'b0, '0);
        drain();

        // random phases, new settings each phase
        for (int ph = 0; ph < 10; ph++) begin
            vals[0] = $urandom; vals[1] = $urandom;
            vals[2] = $urandom; vals[3] = $urandom_range(0, 131071);
            vals[4] = $urandom_range(0, 131071); vals[5] = $urandom_range(0, 31);
            if (ph % 3 == 0) vals[5] = $urandom_range(1, 4);
            if (ph % 2 == 1) vals[0] = $urandom_range(0, 1 << 26);
            for (int r = 0; r < 6; r++)
                if ($urandom_range(0, 2) != 0 || ph == 0) write_reg(3'(r), vals[r]);
            if (ph == 4) begin
                // receiver blocked while frames keep coming
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int i = 0; i < N_RANDOM / 10; i++) send_frame(rand_frame(), 1'b0, '0);
            drain();
        end

        $display("%0d frames sent, %0d results checked, over 10 random register settings",
                 n_sent, n_out);
        if (n_errors == 0 && expected_frames.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout");
        $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
